// ----- hdl/spq_pkg.sv -----
// shared types, constants and helpers for the sorted priority queue
// no dependencies
package spq_pkg;

   localparam int CAPACITY      = 16;
   localparam int DATA_BITS     = 16;
   localparam int PRIORITY_BITS = 16;

   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int SLOT_BITS = DATA_BITS + PRIORITY_BITS;

   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

   localparam int REQ_TDATA_BITS = ((DATA_BITS + PRIORITY_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = DATA_BITS + 2 + CNT_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [DATA_BITS-1:0]     data;
   } slot_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]     mode;
      logic [DATA_BITS-1:0]     data;
      logic [PRIORITY_BITS-1:0] prio;
   } cmd_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] front_data;
      logic                 front_valid;
      logic                 insert_dropped;
      cnt_type              entry_count;
   } res_type;

   // physical slot of a logical position behind the head, wrapping at capacity
   function automatic idx_type wrap_add(idx_type base, cnt_type ofs);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS + 1)'(base) + (CNT_BITS + 1)'(ofs);
      if (sum >= (CNT_BITS + 1)'(CAPACITY)) begin
         sum = sum - (CNT_BITS + 1)'(CAPACITY);
      end
      return sum[IDX_BITS-1:0];
   endfunction

endpackage

// ----- hdl/sorted_priority_queue_top.sv -----
// sorted priority queue, top level with stream channels and result register
// depends on spq_pkg and spq_engine
//
// usage: each req beat carries one operation, selected by req_tuser
// (insert, remove front, clear). entries sit in a circular ram with the
// front at the head pointer, so a remove only advances the head.
// an insert walks from the tail toward the front, moving each entry of
// lower priority back, using a single priority compare and the ram's one read
// and one write port; equal priorities keep arrival order.
// each req beat yields exactly one rsp beat.
// clear, spare mode, dropped insert, empty remove or insert into an empty
// queue go straight to the result; a remove first reads the front entry;
// other inserts move back m entries of lower priority (at most 15), then
// write the new entry in the freed slot.
// req_tready is high only while the engine is idle; with the receiver ready
// it rises again in the same cycle as rsp_tvalid.
// rsp is held in an output register; while the receiver stalls, the engine
// may take and finish one more beat, then holds it with req_tready low.
// reset (synchronous, active high) empties the queue and drops any pending
// beat; ram contents are not cleared and need no clearing pass.
module sorted_priority_queue_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // entry_data, entry_priority
   input  logic [spq_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // mode
   input  logic [spq_pkg::MODE_BITS-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // front_data, front_valid, insert_dropped, entry_count
   output logic [spq_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);

   spq_pkg::cmd_type cmd;
   spq_pkg::res_type res;
   logic eng_ready, eng_res_valid, res_take;
   logic rsp_valid_ff, rsp_valid_in;
   spq_pkg::res_type rsp_res_ff, rsp_res_in;

   assign cmd = '{mode: req_tuser,
                  data: req_tdata[spq_pkg::DATA_BITS-1:0],
                  prio: req_tdata[spq_pkg::DATA_BITS +: spq_pkg::PRIORITY_BITS]};

   spq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd       (cmd),
      .cmd_ready (eng_ready),
      .res_valid (eng_res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   assign req_tready = eng_ready;
   assign res_take   = eng_res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = spq_pkg::RSP_TDATA_BITS'({rsp_res_ff.entry_count,
                                                 rsp_res_ff.insert_dropped,
                                                 rsp_res_ff.front_valid,
                                                 rsp_res_ff.front_data});

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted beat");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_res_ff.front_valid && rsp_res_ff.insert_dropped))
      else $error("front_valid and insert_dropped both set");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_res_ff.entry_count <= spq_pkg::CNT_BITS'(spq_pkg::CAPACITY)))
      else $error("entry_count above capacity");

   a_valid_has_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_res_ff.front_valid) |-> (rsp_res_ff.front_data == '0))
      else $error("front_data nonzero without front_valid");

endmodule

// ----- hdl/spq_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/spq_engine.sv -----
// queue sequencer: keeps slots in a circular ram and walks inserts from the tail
// depends on spq_pkg and spq_ram
module spq_engine (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  spq_pkg::cmd_type cmd,
   output logic            cmd_ready,
   output logic            res_valid,
   output spq_pkg::res_type res,
   input  logic            res_take
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_PLACE = 3'd2;
   localparam logic [2:0] ST_POP   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   spq_pkg::idx_type head_ff, head_in;
   spq_pkg::cnt_type occ_ff, occ_in;
   spq_pkg::cnt_type pos_ff, pos_in;
   logic [spq_pkg::DATA_BITS-1:0] data_ff, data_in;
   logic [spq_pkg::PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [spq_pkg::DATA_BITS-1:0] front_ff, front_in;
   logic fvalid_ff, fvalid_in;
   logic drop_ff, drop_in;

   logic wr_en;
   spq_pkg::idx_type wr_addr, rd_addr;
   spq_pkg::slot_type wr_slot, rd_slot;
   logic [spq_pkg::SLOT_BITS-1:0] rd_raw;

   spq_ram #(
      .WIDTH (spq_pkg::SLOT_BITS),
      .DEPTH (spq_pkg::CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_slot = rd_raw;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      occ_in    = occ_ff;
      pos_in    = pos_ff;
      data_in   = data_ff;
      prio_in   = prio_ff;
      front_in  = front_ff;
      fvalid_in = fvalid_ff;
      drop_in   = drop_ff;
      wr_en     = 1'b0;
      wr_addr   = spq_pkg::wrap_add(head_ff, pos_ff);
      wr_slot   = '{prio: prio_ff, data: data_ff};
      rd_addr   = head_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               data_in   = cmd.data;
               prio_in   = cmd.prio;
               front_in  = '0;
               fvalid_in = 1'b0;
               drop_in   = 1'b0;
               state_in  = ST_DONE;
               unique case (cmd.mode)
                  spq_pkg::MODE_INSERT: begin
                     if (occ_ff == spq_pkg::CNT_BITS'(spq_pkg::CAPACITY)) begin
                        drop_in = 1'b1;
                     end else if (occ_ff == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = head_ff;
                        wr_slot = '{prio: cmd.prio, data: cmd.data};
                        occ_in  = occ_ff + 1'b1;
                     end else begin
                        pos_in   = occ_ff;
                        rd_addr  = spq_pkg::wrap_add(head_ff, occ_ff - 1'b1);
                        state_in = ST_SHIFT;
                     end
                  end
                  spq_pkg::MODE_REMOVE: begin
                     if (occ_ff != '0) begin
                        rd_addr  = head_ff;
                        state_in = ST_POP;
                     end
                  end
                  spq_pkg::MODE_CLEAR: begin
                     occ_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (prio_ff <= rd_slot.prio) begin
               occ_in   = occ_ff + 1'b1;
               state_in = ST_DONE;
            end else begin
               wr_slot = rd_slot;
               pos_in  = pos_ff - 1'b1;
               if (pos_ff == spq_pkg::CNT_BITS'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_addr = spq_pkg::wrap_add(head_ff, pos_ff - spq_pkg::CNT_BITS'(2));
               end
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = head_ff;
            occ_in   = occ_ff + 1'b1;
            state_in = ST_DONE;
         end
         ST_POP: begin
            front_in  = rd_slot.data;
            fvalid_in = 1'b1;
            head_in   = spq_pkg::wrap_add(head_ff, spq_pkg::CNT_BITS'(1));
            occ_in    = occ_ff - 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
      end
      pos_ff    <= pos_in;
      data_ff   <= data_in;
      prio_ff   <= prio_in;
      front_ff  <= front_in;
      fvalid_ff <= fvalid_in;
      drop_ff   <= drop_in;
   end

   assign cmd_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res = '{front_data: front_ff, front_valid: fvalid_ff,
                  insert_dropped: drop_ff, entry_count: occ_ff};

endmodule
